/* rtl/rgd_pkg.sv */
// ----------------------------------------------------------------------------
// rgd_pkg
// Shared types and constants of the rsync greeting detector: queue sizes,
// verdict codes and the classified item that flows from front to back.
// ----------------------------------------------------------------------------
package rgd_pkg;

   // command queue between front and back (depth must be a power of two)
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   // result queue inside the back end (depth must be a power of two)
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam int VERDICT_W = 2;
   localparam logic [VERDICT_W-1:0] VERDICT_IN_PROCESS = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_MATCH      = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_MATCH   = 2'd2;

   // one item after classification by the front end
   typedef struct packed {
      logic empty;       // zero-length packet
      logic last;        // final byte of the packet
      logic resp;        // packet travels from responder
      logic pre_ok;      // byte matches the greeting prefix, or lies past it
      logic ver_ok;      // byte is a version char, or lies inside the prefix
      logic text_ok;     // printable or whitespace
      logic line_end;    // byte is 0x0a
      logic long_enough; // byte position is at least 8
   } cmd_type;

   // between command queue and back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

endpackage

/* rtl/rgd_front.sv */
// ----------------------------------------------------------------------------
// rgd_front
// Accepts payload bytes, tracks the byte position within the packet and
// classifies every byte against the greeting and text character checks.
// ----------------------------------------------------------------------------
module rgd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              last_in_packet,
   input  logic              from_responder,
   input  logic              packet_empty,
   output rgd_pkg::cmd_type  cmd
);

   localparam logic [3:0] PREFIX_LEN = 4'd9;
   localparam logic [3:0] POS_MAX    = 4'd10;
   localparam logic [7:0] LINE_END   = 8'h0A;

   logic [3:0] pos_ff;
   logic [3:0] pos_in;

   function automatic logic [7:0] prefix_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = "@";
         4'd1:    c = "R";
         4'd2:    c = "S";
         4'd3:    c = "Y";
         4'd4:    c = "N";
         4'd5:    c = "C";
         4'd6:    c = "D";
         4'd7:    c = ":";
         4'd8:    c = " ";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_version_char(input logic [7:0] c);
      return ((c >= "0") && (c <= "9")) || (c == ".");
   endfunction

   function automatic logic is_text_char(input logic [7:0] c);
      return ((c >= 8'h20) && (c <= 8'h7E)) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   always_comb begin
      cmd.empty       = packet_empty;
      cmd.last        = last_in_packet;
      cmd.resp        = from_responder;
      cmd.pre_ok      = (pos_ff >= PREFIX_LEN) || (data_byte == prefix_char(pos_ff));
      cmd.ver_ok      = (pos_ff < PREFIX_LEN) || is_version_char(data_byte);
      cmd.text_ok     = is_text_char(data_byte);
      cmd.line_end    = (data_byte == LINE_END);
      cmd.long_enough = (pos_ff >= (PREFIX_LEN - 4'd1));
   end

   // empty packets leave the position alone
   always_comb begin
      pos_in = pos_ff;
      if (accept && !packet_empty) begin
         if (last_in_packet) begin
            pos_in = 4'd0;
         end else if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 4'd0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

/* rtl/rgd_cmd_queue.sv */
// ----------------------------------------------------------------------------
// rgd_cmd_queue
// Small queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module rgd_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rgd_pkg::cmd_type      push_cmd,
   output logic                  full,
   input  logic                  pop,
   output rgd_pkg::cmd_head_type head
);

   rgd_pkg::cmd_type                 entry_ff [rgd_pkg::CMD_DEPTH];
   logic [rgd_pkg::CMD_PTR_W-1:0]    wr_ptr_ff;
   logic [rgd_pkg::CMD_PTR_W-1:0]    wr_ptr_in;
   logic [rgd_pkg::CMD_PTR_W-1:0]    rd_ptr_ff;
   logic [rgd_pkg::CMD_PTR_W-1:0]    rd_ptr_in;
   logic [rgd_pkg::CMD_CNT_W-1:0]    count_ff;
   logic [rgd_pkg::CMD_CNT_W-1:0]    count_in;
   logic                             do_pop;

   assign full       = (count_ff == rgd_pkg::CMD_CNT_W'(rgd_pkg::CMD_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + rgd_pkg::CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + rgd_pkg::CMD_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + rgd_pkg::CMD_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - rgd_pkg::CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* rtl/rgd_back.sv */
// ----------------------------------------------------------------------------
// rgd_back
// Carries out classified items: keeps the flow phase and the per-packet check
// flags, decides the verdict at packet end or empty packet, queues the result.
// ----------------------------------------------------------------------------
module rgd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  rgd_pkg::cmd_head_type           head,
   output logic                            cmd_pop,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rgd_pkg::VERDICT_W-1:0]   rsp_verdict
);

   typedef enum logic [1:0] {
      PH_GREETING = 2'd0,
      PH_MOTD     = 2'd1,
      PH_DONE     = 2'd2
   } phase_type;

   phase_type                         phase_ff;
   phase_type                         phase_in;
   logic                              prefix_good_ff;
   logic                              prefix_good_in;
   logic                              chars_good_ff;
   logic                              chars_good_in;

   logic [rgd_pkg::VERDICT_W-1:0]     rq_ff [rgd_pkg::RSP_DEPTH];
   logic [rgd_pkg::RSP_PTR_W-1:0]     rq_wr_ff;
   logic [rgd_pkg::RSP_PTR_W-1:0]     rq_wr_in;
   logic [rgd_pkg::RSP_PTR_W-1:0]     rq_rd_ff;
   logic [rgd_pkg::RSP_PTR_W-1:0]     rq_rd_in;
   logic [rgd_pkg::RSP_CNT_W-1:0]     rq_cnt_ff;
   logic [rgd_pkg::RSP_CNT_W-1:0]     rq_cnt_in;

   rgd_pkg::cmd_type                  c;
   logic                              room;
   logic                              out_take;
   logic                              res_push;
   logic [rgd_pkg::VERDICT_W-1:0]     res_verdict;
   logic                              pre;

   assign c           = head.cmd;
   assign rsp_empty   = (rq_cnt_ff == '0);
   assign rsp_verdict = rq_ff[rq_rd_ff];
   assign out_take    = rsp_pop && !rsp_empty;
   assign room        = (rq_cnt_ff != rgd_pkg::RSP_CNT_W'(rgd_pkg::RSP_DEPTH)) || out_take;
   assign cmd_pop     = head.valid && room;
   assign pre         = prefix_good_ff && c.pre_ok;

   always_comb begin
      phase_in       = phase_ff;
      prefix_good_in = prefix_good_ff;
      chars_good_in  = chars_good_ff;
      res_push       = 1'b0;
      res_verdict    = rgd_pkg::VERDICT_IN_PROCESS;
      if (cmd_pop) begin
         if (c.empty) begin
            res_push = 1'b1;
         end else if (!c.last) begin
            prefix_good_in = pre;
            if (phase_ff == PH_GREETING) begin
               chars_good_in = chars_good_ff && c.ver_ok;
            end else begin
               chars_good_in = chars_good_ff && c.text_ok;
            end
         end else begin
            res_push       = 1'b1;
            prefix_good_in = 1'b1;
            chars_good_in  = 1'b1;
            if (c.resp) begin
               case (phase_ff)
                  PH_GREETING: begin
                     if (c.long_enough && pre && chars_good_ff && c.line_end) begin
                        phase_in = PH_MOTD;
                     end else begin
                        res_verdict = rgd_pkg::VERDICT_NO_MATCH;
                     end
                  end
                  PH_MOTD: begin
                     if (chars_good_ff && c.line_end) begin
                        phase_in    = PH_DONE;
                        res_verdict = rgd_pkg::VERDICT_MATCH;
                     end else begin
                        res_verdict = rgd_pkg::VERDICT_NO_MATCH;
                     end
                  end
                  default: begin
                     res_verdict = rgd_pkg::VERDICT_NO_MATCH;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      rq_wr_in  = res_push ? rq_wr_ff + rgd_pkg::RSP_PTR_W'(1) : rq_wr_ff;
      rq_rd_in  = out_take ? rq_rd_ff + rgd_pkg::RSP_PTR_W'(1) : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (res_push && !out_take) begin
         rq_cnt_in = rq_cnt_ff + rgd_pkg::RSP_CNT_W'(1);
      end else if (!res_push && out_take) begin
         rq_cnt_in = rq_cnt_ff - rgd_pkg::RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_GREETING;
         prefix_good_ff <= 1'b1;
         chars_good_ff  <= 1'b1;
         rq_wr_ff       <= '0;
         rq_rd_ff       <= '0;
         rq_cnt_ff      <= '0;
      end else begin
         phase_ff       <= phase_in;
         prefix_good_ff <= prefix_good_in;
         chars_good_ff  <= chars_good_in;
         rq_wr_ff       <= rq_wr_in;
         rq_rd_ff       <= rq_rd_in;
         rq_cnt_ff      <= rq_cnt_in;
      end
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res_verdict;
      end
   end

endmodule

/* rtl/rsync_greeting_detector.sv */
// ----------------------------------------------------------------------------
// rsync_greeting_detector
// Classifies one TCP flow as rsync from its payload bytes.
// ----------------------------------------------------------------------------
// Takes one payload byte per clock while req_full is low and gives one verdict
// for every packet end or empty packet (0 in process, 1 rsync matched, 2 no
// match). The front end classifies each byte as it is accepted and writes it
// into a 4-entry command queue; the back end takes one entry per clock while
// its 2-entry result queue has room, keeps the flow phase and writes verdicts
// into that queue, from which they show on rsp_verdict. full rises only when
// both queues have filled because results are not being popped.
// ----------------------------------------------------------------------------
module rsync_greeting_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_in_packet,
   input  logic                            req_from_responder,
   input  logic                            req_packet_empty,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rgd_pkg::VERDICT_W-1:0]   rsp_verdict
);

   logic                  accept;
   rgd_pkg::cmd_type      cmd;
   rgd_pkg::cmd_head_type head;
   logic                  cmd_pop;

   assign accept = req_push && !req_full;

   rgd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .last_in_packet (req_last_in_packet),
      .from_responder (req_from_responder),
      .packet_empty   (req_packet_empty),
      .cmd            (cmd)
   );

   rgd_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_cmd (cmd),
      .full     (req_full),
      .pop      (cmd_pop),
      .head     (head)
   );

   rgd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .cmd_pop     (cmd_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_verdict (rsp_verdict)
   );

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rsync greeting detector.
// ----------------------------------------------------------------------------
// A queue of payload bytes is built up front. It starts with a few edge cases,
// then carries random greetings and message-of-the-day lines, most of them
// broken, so the flow moves through every phase. A driver pushes the bytes in
// bursts and a monitor pops verdicts on its own stall pattern. Each accepted
// item runs through a local model of the flow, and every popped verdict is
// compared with the oldest one that the model expects.
// ----------------------------------------------------------------------------
module testbench;

   typedef enum logic [1:0] {
      PH_GREETING = 2'd0,
      PH_MOTD     = 2'd1,
      PH_DONE     = 2'd2
   } flow_phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_in_packet;
      logic       from_responder;
      logic       packet_empty;
      logic       drain_first;    // sender waits until no verdict is outstanding
   } flow_item_type;

   localparam int              PREFIX_LEN = 9;
   localparam logic [71:0]     GREETING   = "@RSYNCD: ";
   localparam logic [7:0]      LINE_END   = 8'h0a;
   localparam int              HOLD_LONG  = 120;
   localparam int              LIMIT      = 200000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic [7:0]                    req_data_byte = 8'd0;
   logic                          req_last_in_packet = 1'b0;
   logic                          req_from_responder = 1'b0;
   logic                          req_packet_empty = 1'b0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic [rgd_pkg::VERDICT_W-1:0] rsp_verdict;

   // flow model
   flow_phase_type flow_phase     = PH_GREETING;
   logic [3:0]     flow_pos       = 4'd0;
   logic           flow_prefix_ok = 1'b1;
   logic           flow_chars_ok  = 1'b1;

   flow_item_type                 pending[$];
   logic [rgd_pkg::VERDICT_W-1:0] verdicts_due[$];
   logic [7:0]                    pkt_bytes[$];
   logic                          drain_next = 1'b0;
   int                            planned_items = 0;
   int                            planned_results = 0;
   logic                          greeting_sent = 1'b0;
   logic                          motd_sent = 1'b0;

   int errors = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int full_stalls = 0;
   int verdict_seen[4] = '{0, 0, 0, 0};

   // driver and monitor state
   logic                          drv_offer;
   int                            burst_left = 0;
   int                            gap_left = 0;
   logic                          pop_next;
   int                            pop_mode = 0;
   int                            pattern_count = 0;
   int                            hold_left = 0;
   logic [rgd_pkg::VERDICT_W-1:0] want;

   always #6 clock = ~clock;

   rsync_greeting_detector u_top (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_last_in_packet (req_last_in_packet),
      .req_from_responder (req_from_responder),
      .req_packet_empty   (req_packet_empty),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_verdict        (rsp_verdict)
   );

   function automatic logic [7:0] prefix_char(input int idx);
      return GREETING[8*(PREFIX_LEN-1-idx) +: 8];
   endfunction

   function automatic logic is_version(input logic [7:0] b);
      return (b >= "0" && b <= "9") || b == ".";
   endfunction

   function automatic logic is_text(input logic [7:0] b);
      return (b >= 8'h20 && b <= 8'h7e) || (b >= 8'h09 && b <= 8'h0d);
   endfunction

   task automatic predict_verdict(input flow_item_type it);
      logic [3:0]                    pos;
      logic                          pre;
      logic                          chr;
      logic [rgd_pkg::VERDICT_W-1:0] v;
      pos = flow_pos;
      pre = flow_prefix_ok;
      chr = flow_chars_ok;
      if (it.packet_empty) begin
         // empty packet leaves a packet in progress untouched
         verdicts_due.push_back(rgd_pkg::VERDICT_IN_PROCESS);
      end else begin
         if (pos < PREFIX_LEN && it.data_byte != prefix_char(int'(pos)))
            pre = 1'b0;
         if (!it.last_in_packet) begin
            if (flow_phase == PH_GREETING) begin
               if (pos >= PREFIX_LEN && !is_version(it.data_byte))
                  chr = 1'b0;
            end else if (!is_text(it.data_byte)) begin
               chr = 1'b0;
            end
            flow_prefix_ok = pre;
            flow_chars_ok  = chr;
            if (pos < 4'd10)
               flow_pos = pos + 4'd1;
         end else begin
            // direction of the packet is that of its last byte
            if (!it.from_responder) begin
               v = rgd_pkg::VERDICT_IN_PROCESS;
            end else begin
               case (flow_phase)
                  PH_GREETING: begin
                     if (pos >= PREFIX_LEN - 1 && pre && chr && it.data_byte == LINE_END) begin
                        flow_phase = PH_MOTD;
                        v = rgd_pkg::VERDICT_IN_PROCESS;
                     end else begin
                        v = rgd_pkg::VERDICT_NO_MATCH;
                     end
                  end
                  PH_MOTD: begin
                     if (chr && it.data_byte == LINE_END) begin
                        flow_phase = PH_DONE;
                        v = rgd_pkg::VERDICT_MATCH;
                     end else begin
                        v = rgd_pkg::VERDICT_NO_MATCH;
                     end
                  end
                  default: v = rgd_pkg::VERDICT_NO_MATCH;
               endcase
            end
            flow_pos       = 4'd0;
            flow_prefix_ok = 1'b1;
            flow_chars_ok  = 1'b1;
            verdicts_due.push_back(v);
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic add_item(input logic [7:0] b, input logic last, input logic resp,
                           input logic empty);
      flow_item_type it;
      it.data_byte      = b;
      it.last_in_packet = last;
      it.from_responder = resp;
      it.packet_empty   = empty;
      it.drain_first    = drain_next;
      drain_next = 1'b0;
      pending.push_back(it);
      planned_items++;
      if (last || empty)
         planned_results++;
   endtask

   task automatic flush_packet(input logic resp);
      int  n;
      logic lst;
      n = pkt_bytes.size();
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 15) == 0)
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b1);
         lst = (i == n - 1);
         add_item(pkt_bytes[i], lst, lst ? resp : 1'($urandom_range(0, 1)), 1'b0);
      end
      if (n == 0)
         add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 1'b1);
   endtask

   function automatic logic [7:0] version_char();
      int r;
      r = $urandom_range(0, 10);
      return (r == 10) ? 8'(".") : 8'("0" + r);
   endfunction

   function automatic logic [7:0] text_char();
      return ($urandom_range(0, 9) == 0) ? 8'($urandom_range(9, 13)) : 8'($urandom_range(32, 126));
   endfunction

   function automatic logic [7:0] bad_char();
      int r;
      r = $urandom_range(0, 2);
      if (r == 0) return 8'($urandom_range(0, 8));
      else if (r == 1) return 8'($urandom_range(14, 31));
      else return 8'($urandom_range(127, 255));
   endfunction

   // flaw 0 well formed, 1 prefix byte, 2 version byte, 3 last byte, 4 too short
   task automatic build_greeting(input int flaw);
      int nver;
      int k;
      pkt_bytes.delete();
      for (k = 0; k < PREFIX_LEN; k++)
         pkt_bytes.push_back(prefix_char(k));
      // long versions push the byte position into saturation
      nver = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 14) : $urandom_range(0, 5);
      for (k = 0; k < nver; k++)
         pkt_bytes.push_back(version_char());
      pkt_bytes.push_back(LINE_END);
      case (flaw)
         1: pkt_bytes[$urandom_range(0, PREFIX_LEN - 1)] = 8'($urandom_range(0, 255));
         2: begin
            if (nver > 0)
               pkt_bytes[PREFIX_LEN + $urandom_range(0, nver - 1)] = 8'($urandom_range(0, 255));
            else
               pkt_bytes.insert(PREFIX_LEN, 8'($urandom_range(0, 255)));
         end
         3: pkt_bytes[pkt_bytes.size() - 1] = 8'($urandom_range(0, 255));
         4: begin
            k = $urandom_range(1, PREFIX_LEN - 1);
            while (pkt_bytes.size() > k)
               void'(pkt_bytes.pop_back());
            if ($urandom_range(0, 1) == 1)
               pkt_bytes.push_back(LINE_END);
         end
         default: ;
      endcase
   endtask

   // flaw 0 well formed, 1 bad char inside, 2 random last byte, 3 text last byte
   task automatic build_motd(input int flaw);
      int len;
      len = $urandom_range(0, 24);
      pkt_bytes.delete();
      for (int k = 0; k < len; k++)
         pkt_bytes.push_back(text_char());
      pkt_bytes.push_back(LINE_END);
      case (flaw)
         1: pkt_bytes.insert($urandom_range(0, len), bad_char());
         2: pkt_bytes[len] = 8'($urandom_range(0, 255));
         3: pkt_bytes[len] = text_char();
         default: ;
      endcase
   endtask

   task automatic build_noise();
      int len;
      len = $urandom_range(1, 12);
      pkt_bytes.delete();
      for (int k = 0; k < len; k++)
         pkt_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   function automatic int flow_plan_stage();
      if (planned_items < 150) return 0;
      else if (planned_items < 290) return 1;
      else return 2;
   endfunction

   task automatic build_stimulus();
      int r;
      // edge cases, all while still in the greeting phase
      add_item(8'hff, 1'b1, 1'b1, 1'b1);
      add_item(8'h00, 1'b1, 1'b0, 1'b0);
      add_item(8'hff, 1'b1, 1'b1, 1'b0);
      add_item(8'h00, 1'b1, 1'b1, 1'b0);
      add_item("@", 1'b0, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b0, 1'b1);
      add_item(LINE_END, 1'b1, 1'b1, 1'b0);
      // greeting without its trailing space, one byte short
      pkt_bytes.delete();
      for (int k = 0; k < PREFIX_LEN - 1; k++)
         pkt_bytes.push_back(prefix_char(k));
      pkt_bytes.push_back(LINE_END);
      flush_packet(1'b1);
      add_item(8'h80, 1'b0, 1'b0, 1'b0);
      add_item(8'h7f, 1'b1, 1'b1, 1'b0);

      // random part: broken greetings, then the greeting, then the motd lines
      while (planned_items < 420 || planned_results < 60) begin
         if (flow_plan_stage() == 1 && !greeting_sent) begin
            greeting_sent = 1'b1;
            drain_next = 1'b1;
            build_greeting(0);
            flush_packet(1'b1);
         end else if (flow_plan_stage() == 2 && !motd_sent) begin
            motd_sent = 1'b1;
            drain_next = 1'b1;
            build_motd(0);
            flush_packet(1'b1);
         end
         if ($urandom_range(0, 40) == 0)
            drain_next = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 8) begin
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b1);
         end else if (r < 20) begin
            build_noise();
            flush_packet(1'b0);
         end else if (r < 26) begin
            build_noise();
            flush_packet(1'b1);
         end else begin
            case (flow_plan_stage())
               0: build_greeting($urandom_range(1, 4));
               1: begin
                  if ($urandom_range(0, 4) == 0)
                     build_greeting($urandom_range(0, 4));
                  else
                     build_motd($urandom_range(1, 3));
               end
               default: begin
                  if ($urandom_range(0, 1) == 0)
                     build_greeting($urandom_range(0, 4));
                  else
                     build_motd($urandom_range(0, 3));
               end
            endcase
            flush_packet($urandom_range(0, 7) != 0);
         end
      end
   endtask

   // ------------------------------------------------------------------ driver

   always @(posedge clock) begin
      if (reset) begin
         req_push           <= 1'b0;
         req_data_byte      <= 8'd0;
         req_last_in_packet <= 1'b0;
         req_from_responder <= 1'b0;
         req_packet_empty   <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_verdict(pending.pop_front());
            items_accepted++;
         end
         if (req_push && req_full)
            full_stalls++;
         drv_offer = 1'b0;
         if (req_push && req_full) begin
            drv_offer = 1'b1;   // same item stays on offer
         end else if (pending.size() > 0) begin
            if (pending[0].drain_first && verdicts_due.size() != 0) begin
               drv_offer = 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
            end else begin
               drv_offer = 1'b1;
               if (burst_left > 0)
                  burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
         if (drv_offer) begin
            req_push           <= 1'b1;
            req_data_byte      <= pending[0].data_byte;
            req_last_in_packet <= pending[0].last_in_packet;
            req_from_responder <= pending[0].from_responder;
            req_packet_empty   <= pending[0].packet_empty;
         end else begin
            req_push           <= 1'b0;
            req_data_byte      <= 8'($urandom_range(0, 255));
            req_last_in_packet <= 1'($urandom_range(0, 1));
            req_from_responder <= 1'($urandom_range(0, 1));
            req_packet_empty   <= 1'($urandom_range(0, 1));
         end
      end
   end

   // ----------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (verdicts_due.size() == 0) begin
               errors++;
               $display("%0t: verdict %0d popped, expected none", $time, rsp_verdict);
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want) begin
                  errors++;
                  $display("%0t: verdict mismatch, expected %0d, actual %0d",
                           $time, want, rsp_verdict);
               end
               verdict_seen[want]++;
               results_checked++;
               // long hold-offs so both internal queues fill and full rises
               if (results_checked == 15 || results_checked == 40)
                  hold_left = HOLD_LONG;
            end
         end
         pattern_count++;
         if (pattern_count % 64 == 0)
            pop_mode = $urandom_range(0, 2);
         if (hold_left > 0) begin
            hold_left--;
            pop_next = 1'b0;
         end else begin
            case (pop_mode)
               0: pop_next = 1'b1;
               1: pop_next = 1'($urandom_range(0, 1));
               default: pop_next = ($urandom_range(0, 3) == 0);
            endcase
         end
         rsp_pop <= pop_next;
      end
   end

   // -------------------------------------------------------------------- flow

   initial begin
      build_stimulus();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (pending.size() > 0)
         @(posedge clock);
      while (verdicts_due.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d bytes and %0d verdicts (%0d in process, %0d match, %0d no match)",
               items_accepted, results_checked, verdict_seen[rgd_pkg::VERDICT_IN_PROCESS],
               verdict_seen[rgd_pkg::VERDICT_MATCH], verdict_seen[rgd_pkg::VERDICT_NO_MATCH]);
      $display("push held off by full on %0d cycles, flow ended in phase %0d",
               full_stalls, flow_phase);
      if (errors == 0)
         $display("PASS rsync_greeting_detector");
      else
         $display("FAIL rsync_greeting_detector");
      $finish;
   end

   initial begin
      #(12 * LIMIT);
      $display("timeout after %0d cycles", LIMIT);
      $display("FAIL rsync_greeting_detector");
      $finish;
   end

endmodule

/* rsync_greeting_detector.f */
rtl/rgd_pkg.sv
rtl/rgd_front.sv
rtl/rgd_cmd_queue.sv
rtl/rgd_back.sv
rtl/rsync_greeting_detector.sv
bench/testbench.sv
